/* rtl/vcp_pkg.sv */
// ----------------------------------------------------------------------------
// vcp_pkg
// Shared types and constants of the velocity change keypoint picker.
// ----------------------------------------------------------------------------
package vcp_pkg;

  localparam int VCP_CHANNELS = 16;

  localparam int CH_W    = 4;
  localparam int VEL_W   = 32;
  localparam int THR_W   = 31;
  localparam int CNT_W   = 10;
  localparam int CAUSE_W = 3;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [CNT_W-1:0] MIN_INTERVAL_RST = CNT_W'(1);
  localparam logic [CNT_W-1:0] MAX_INTERVAL_RST = CNT_W'(10);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 1'b1;

  // input commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_THRESH = 1'b1;

  // stored direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_RISE = 2'd1;
  localparam logic [1:0] DIR_FALL = 2'd3;

  // queue between front and back
  localparam int QDEPTH = 2;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE  = 3'd0,
    CAUSE_MAG   = 3'd1,
    CAUSE_REV   = 3'd2,
    CAUSE_MAXI  = 3'd3,
    CAUSE_FIRST = 3'd4,
    CAUSE_LAST  = 3'd5
  } cause_t;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_IGNORE = 2'd1,
    OP_THRESH = 2'd2
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [CH_W-1:0]        channel;
    logic signed [VEL_W-1:0] velocity;
    logic [THR_W-1:0]       threshold_value;
    logic                   first_sample;
    logic                   last_sample;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] min_interval;
    logic [CNT_W-1:0] max_interval;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic pop_result;
  } back_stat_t;

endpackage

/* rtl/vcp_if.sv */
// ----------------------------------------------------------------------------
// vcp_if
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface vcp_in_if import vcp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [CH_W-1:0]         channel;
  logic signed [VEL_W-1:0] velocity;
  logic [THR_W-1:0]        threshold_value;
  logic                    first_sample;
  logic                    last_sample;

  modport source (
    output valid, command, channel, velocity, threshold_value, first_sample, last_sample,
    input  ready
  );
  modport sink (
    input  valid, command, channel, velocity, threshold_value, first_sample, last_sample,
    output ready
  );
endinterface

interface vcp_out_if import vcp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    out_channel;
  logic               is_keypoint;
  logic [CAUSE_W-1:0] cause;

  modport source (
    output valid, out_channel, is_keypoint, cause,
    input  ready
  );
  modport sink (
    input  valid, out_channel, is_keypoint, cause,
    output ready
  );
endinterface

/* rtl/vcp_front.sv */
// ----------------------------------------------------------------------------
// vcp_front
// Accepts input items, classifies them and pushes them into the queue; threshold writes
// to a missing channel are dropped.
module vcp_front import vcp_pkg::*; #(
  parameter int CHANNELS = VCP_CHANNELS
) (
  vcp_in_if.sink   in_chan,
  input  q_stat_t  q_stat,
  output logic     push,
  output entry_t   push_entry
);

  logic ch_ok;
  logic xfer;

  assign ch_ok = ({26'd0, in_chan.channel} < 30'(CHANNELS));

  assign in_chan.ready = !q_stat.full;
  assign xfer          = in_chan.valid && in_chan.ready;

  always_comb begin
    push_entry.channel         = in_chan.channel;
    push_entry.velocity        = in_chan.velocity;
    push_entry.threshold_value = in_chan.threshold_value;
    push_entry.first_sample    = in_chan.first_sample;
    push_entry.last_sample     = in_chan.last_sample;
    push                       = xfer;
    if (in_chan.command == CMD_THRESH) begin
      push_entry.op = OP_THRESH;
      // threshold write to a missing channel is dropped here
      if (!ch_ok) begin
        push = 1'b0;
      end
    end else if (ch_ok) begin
      push_entry.op = OP_SAMPLE;
    end else begin
      push_entry.op = OP_IGNORE;
    end
  end

endmodule

/* rtl/vcp_queue.sv */
// ----------------------------------------------------------------------------
// vcp_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module vcp_queue import vcp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  head,
  output q_stat_t q_stat
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_QW = $clog2(QDEPTH + 1);

  entry_t              mem_r [QDEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]   count_r, count_nxt;

  assign q_stat.full  = (count_r == CNT_QW'(QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* rtl/vcp_back.sv */
// ----------------------------------------------------------------------------
// vcp_back
// Judges samples against per-channel state and drives the result register.
// ----------------------------------------------------------------------------
module vcp_back import vcp_pkg::*; #(
  parameter int CHANNELS = VCP_CHANNELS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  entry_t      head,
  input  q_stat_t     q_stat,
  output logic        pop,
  output back_stat_t  back_stat,
  vcp_out_if.source   out_chan
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [VEL_W-1:0] prev_vel_r [CHANNELS];
  logic signed [VEL_W-1:0] key_vel_r  [CHANNELS];
  logic [1:0]              dir_r      [CHANNELS];
  logic [CNT_W-1:0]        cnt_r      [CHANNELS];
  logic [THR_W-1:0]        thr_r      [CHANNELS];

  logic               out_valid_r;
  logic [CH_W-1:0]    out_channel_r;
  cause_t             out_cause_r;

  logic [IDX_W-1:0]        idx;
  logic                    out_free;
  logic                    is_sample;
  logic signed [VEL_W:0]   d;
  logic signed [VEL_W:0]   c;
  logic [VEL_W:0]          mag;
  logic [1:0]              sd;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    ge_min;
  logic                    rev;
  cause_t                  cause;
  cause_t                  res_cause;

  assign idx       = IDX_W'({{IDX_W{1'b0}}, head.channel});
  assign out_free  = !out_valid_r || out_chan.ready;
  assign is_sample = (head.op == OP_SAMPLE) || (head.op == OP_IGNORE);

  // threshold writes drain even while the result register is blocked
  assign pop = !q_stat.empty && ((head.op == OP_THRESH) || out_free);
  assign back_stat.pop        = pop;
  assign back_stat.pop_result = pop && is_sample;

  always_comb begin
    d   = {head.velocity[VEL_W-1], head.velocity} -
          {prev_vel_r[idx][VEL_W-1], prev_vel_r[idx]};
    c   = {head.velocity[VEL_W-1], head.velocity} -
          {key_vel_r[idx][VEL_W-1], key_vel_r[idx]};
    mag = c[VEL_W] ? (VEL_W+1)'(0) - c : c;
    if (d[VEL_W]) begin
      sd = DIR_FALL;
    end else if (d != '0) begin
      sd = DIR_RISE;
    end else begin
      sd = DIR_NONE;
    end
    cnt_inc = (cnt_r[idx] == COUNT_MAX) ? cnt_r[idx] : cnt_r[idx] + 1'b1;
    ge_min  = (cnt_inc >= cfg.min_interval);
    rev     = ((dir_r[idx] == DIR_RISE) && (sd == DIR_FALL)) ||
              ((dir_r[idx] == DIR_FALL) && (sd == DIR_RISE));

    if (head.first_sample) begin
      cause = CAUSE_FIRST;
    end else if (ge_min && (mag > {2'b00, thr_r[idx]})) begin
      cause = CAUSE_MAG;
    end else if (ge_min && rev) begin
      cause = CAUSE_REV;
    end else if (cnt_inc >= cfg.max_interval) begin
      cause = CAUSE_MAXI;
    end else if (head.last_sample) begin
      cause = CAUSE_LAST;
    end else begin
      cause = CAUSE_NONE;
    end
    res_cause = (head.op == OP_SAMPLE) ? cause : CAUSE_NONE;
  end

  // per-channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prev_vel_r[i] <= '0;
        key_vel_r[i]  <= '0;
        dir_r[i]      <= DIR_NONE;
        cnt_r[i]      <= '0;
        thr_r[i]      <= '0;
      end
    end else if (pop) begin
      case (head.op)
        OP_THRESH: begin
          thr_r[idx] <= head.threshold_value;
        end
        OP_SAMPLE: begin
          prev_vel_r[idx] <= head.velocity;
          if (head.first_sample) begin
            key_vel_r[idx] <= head.velocity;
            cnt_r[idx]     <= '0;
            dir_r[idx]     <= DIR_NONE;
          end else begin
            if (!ge_min) begin
              dir_r[idx] <= sd;
            end
            if (cause != CAUSE_NONE) begin
              key_vel_r[idx] <= head.velocity;
              cnt_r[idx]     <= '0;
            end else begin
              cnt_r[idx] <= cnt_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && is_sample) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_sample) begin
      out_channel_r <= head.channel;
      out_cause_r   <= res_cause;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_channel = out_channel_r;
  assign out_chan.cause       = out_cause_r;
  assign out_chan.is_keypoint = (out_cause_r != CAUSE_NONE);

endmodule

/* rtl/velocity_change_keypoint_picker.sv */
// ----------------------------------------------------------------------------
// velocity_change_keypoint_picker
// Flags keypoints in a per-channel stream of Q16.16 velocity samples.
// ----------------------------------------------------------------------------
// path: an input transfer writes the queue, then the judge pops the entry into the result register
// throughput: one item per cycle while the result register is not blocked, set by the state read-modify-write
// reset: channel state and thresholds clear at once, intervals go to 1 and 10
module velocity_change_keypoint_picker import vcp_pkg::*; #(
  parameter int CHANNELS = VCP_CHANNELS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  vcp_in_if.sink               in_chan,
  vcp_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t       cfg_r;
  logic       push;
  entry_t     push_entry;
  logic       pop;
  entry_t     head;
  q_stat_t    q_stat;
  back_stat_t back_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_interval <= MIN_INTERVAL_RST;
      cfg_r.max_interval <= MAX_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_INTERVAL: cfg_r.min_interval <= cfg_wdata;
        REG_MAX_INTERVAL: cfg_r.max_interval <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  vcp_front #(.CHANNELS(CHANNELS)) u_front (
    .in_chan    (in_chan),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  vcp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  vcp_back #(.CHANNELS(CHANNELS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .back_stat (back_stat),
    .out_chan  (out_chan)
  );

  // input stalls only when the queue is full
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> q_stat.full)
    else $error("input stalled with queue space left");

  // every judged sample shows up as a result next cycle
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.pop_result |=> out_chan.valid)
    else $error("sample popped without a result");

  // a threshold write into an empty result slot yields no result
  a_thresh_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (back_stat.pop && !back_stat.pop_result && !out_chan.valid) |=> !out_chan.valid)
    else $error("threshold write produced a result");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue underflow");

endmodule
